// ----- sv/sorted_list_insert_remove_core_macros.svh -----
// Assertion macros for the sorted list core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SORTED_LIST_INSERT_REMOVE_CORE_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SLRI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define SLRI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- sv/slri_pkg.sv -----
// Shared types and constants for the sorted list core.
// No dependencies; used by every module of the block.
`default_nettype none

package slri_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_FULL   = 2'd1,
		ERR_ABSENT = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_STREAM
	} state_t;

	typedef struct packed {
		logic                    req_type;
		logic signed [VAL_W-1:0] operand_value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] list_value;
		logic                    is_last;
		logic                    list_empty;
		logic [1:0]              request_error;
	} res_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [VAL_W-1:0] wr_data;
	} mem_req_t;

endpackage

`default_nettype wire

// ----- sv/sorted_list_insert_remove_core.sv -----
// Sorted list core: keeps up to CAPACITY signed 32-bit values in ascending order,
// inserting before the first greater value and removing the first equal value, then
// streams the whole list out after every request. A request first runs a locate pass
// that reads the stored entries in order, then a stream pass that reads them again and
// emits the new list, held while the output register is stalled; both
// passes go through the single read port of the value store. A new request is taken
// once the last result has gone into the output register. Depends on slri_pkg,
// slri_store, slri_out and the macros header.
`default_nettype none

`include "sorted_list_insert_remove_core_macros.svh"

module sorted_list_insert_remove_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  slri_pkg::req_t      req_item,
	output logic                res_valid,
	input  wire                 res_stall,
	output slri_pkg::res_t      res_item
);

	localparam int CNT_W = slri_pkg::CNT_W;
	localparam int IDX_W = slri_pkg::IDX_W;
	localparam int VAL_W = slri_pkg::VAL_W;

	// control state
	slri_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;          // stored entries, cells 0 .. cnt_q-1 hold the list
	logic [CNT_W-1:0] ctr_q;          // read issue counter, shared by both passes
	logic             vld_s1;         // a read is returning this cycle
	logic [CNT_W-1:0] idx_s1;         // position that read belongs to
	logic             found_q;
	logic [CNT_W-1:0] pos_q;          // insert slot / entry to remove
	slri_pkg::err_t   err_q;
	logic [CNT_W-1:0] nnew_q;         // list length after this request

	// payload
	slri_pkg::req_t          req_q;
	logic [VAL_W-1:0]        prev_q;  // previous old entry, for the shift up after an insert

	slri_pkg::mem_req_t      mreq;
	logic [VAL_W-1:0]        rd_data_s1;
	slri_pkg::res_t          load_item;
	logic                    load;
	logic                    out_ready;

	logic                    is_ins;
	logic                    ins_ok;
	logic                    scan_iss;
	logic                    scan_done;
	logic                    str_iss;
	logic                    rm_shift;
	logic [CNT_W-1:0]        str_addr;
	logic                    hit;
	logic                    list_emp;
	logic                    last_res;
	logic                    acc;
	slri_pkg::err_t          err_d;
	logic [CNT_W-1:0]        nnew_d;

	slri_store u_store (
		.clk        (clk),
		.mreq       (mreq),
		.rd_data_s1 (rd_data_s1)
	);

	slri_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.load_item (load_item),
		.ready     (out_ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	assign is_ins = (req_q.req_type == slri_pkg::REQ_INSERT);
	assign ins_ok = is_ins && (err_q == slri_pkg::ERR_NONE);

	// Locate pass compares the returning entry: insert stops at the first greater
	// value, remove at the first equal one.
	assign hit = is_ins ? ($signed(rd_data_s1) > $signed(req_q.operand_value))
	                    : ($signed(rd_data_s1) == $signed(req_q.operand_value));

	assign scan_iss  = (state_q == slri_pkg::ST_SCAN) && (ctr_q < cnt_q);
	assign scan_done = (state_q == slri_pkg::ST_SCAN) && (ctr_q == cnt_q) && !vld_s1;

	// Rewrite pass: result j is written back to cell j in the cycle it is loaded into
	// the output register. Reads run at or ahead of the write address, so a cell is always
	// read before it is overwritten; no forwarding needed.
	assign str_iss  = (state_q == slri_pkg::ST_STREAM) && (ctr_q < nnew_q) && out_ready;
	assign rm_shift = !is_ins && (err_q == slri_pkg::ERR_NONE) && (ctr_q >= pos_q);
	assign str_addr = ctr_q + CNT_W'(rm_shift);

	assign list_emp = (nnew_q == '0);
	assign last_res = list_emp || (idx_s1 == nnew_q - CNT_W'(1));
	assign load     = (state_q == slri_pkg::ST_STREAM) && out_ready && (vld_s1 || list_emp);
	assign acc      = req_valid && !req_stall;

	always_comb begin
		err_d  = slri_pkg::ERR_NONE;
		nnew_d = cnt_q;
		if (is_ins) begin
			if (cnt_q == CNT_W'(slri_pkg::CAPACITY)) begin
				err_d = slri_pkg::ERR_FULL;
			end else begin
				nnew_d = cnt_q + CNT_W'(1);
			end
		end else begin
			if (!found_q) begin
				err_d = slri_pkg::ERR_ABSENT;
			end else begin
				nnew_d = cnt_q - CNT_W'(1);
			end
		end
	end

	// result value: insert shifts entries past the slot up by one
	always_comb begin
		load_item.list_value    = $signed(rd_data_s1);
		load_item.is_last       = last_res;
		load_item.list_empty    = list_emp;
		load_item.request_error = err_q;
		if (list_emp) begin
			load_item.list_value = '0;
		end else if (ins_ok && (idx_s1 == pos_q)) begin
			load_item.list_value = req_q.operand_value;
		end else if (ins_ok && (idx_s1 > pos_q)) begin
			load_item.list_value = $signed(prev_q);
		end
	end

	always_comb begin
		mreq.rd_en   = 1'b0;
		mreq.rd_addr = ctr_q[IDX_W-1:0];
		mreq.wr_en   = 1'b0;
		mreq.wr_addr = idx_s1[IDX_W-1:0];
		mreq.wr_data = load_item.list_value;
		if (scan_iss) begin
			mreq.rd_en = 1'b1;
		end else if (str_iss && (str_addr < cnt_q)) begin
			mreq.rd_en   = 1'b1;
			mreq.rd_addr = str_addr[IDX_W-1:0];
		end
		// an unchanged list is not written back
		if ((state_q == slri_pkg::ST_STREAM) && vld_s1 && out_ready
		    && (err_q == slri_pkg::ERR_NONE)) begin
			mreq.wr_en = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		case (state_q)
			slri_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = slri_pkg::ST_SCAN;
				end
			end
			slri_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = slri_pkg::ST_STREAM;
				end
			end
			slri_pkg::ST_STREAM: begin
				if (load && last_res) begin
					state_d = slri_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = slri_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slri_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ctr_q   <= '0;
			vld_s1  <= 1'b0;
			idx_s1  <= '0;
			found_q <= 1'b0;
			pos_q   <= '0;
			err_q   <= slri_pkg::ERR_NONE;
			nnew_q  <= '0;
		end else begin
			case (state_q)
				slri_pkg::ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (acc) begin
						ctr_q   <= '0;
						found_q <= 1'b0;
						pos_q   <= cnt_q;
					end
				end
				slri_pkg::ST_SCAN: begin
					vld_s1 <= scan_iss;
					idx_s1 <= ctr_q;
					if (scan_iss) begin
						ctr_q <= ctr_q + CNT_W'(1);
					end
					if (vld_s1 && !found_q && hit) begin
						found_q <= 1'b1;
						pos_q   <= idx_s1;
					end
					if (scan_done) begin
						ctr_q  <= '0;
						err_q  <= err_d;
						nnew_q <= nnew_d;
					end
				end
				slri_pkg::ST_STREAM: begin
					if (out_ready) begin
						vld_s1 <= str_iss;
						idx_s1 <= ctr_q;
					end
					if (str_iss) begin
						ctr_q <= ctr_q + CNT_W'(1);
					end
					if (load && last_res) begin
						cnt_q <= nnew_q;
					end
				end
				default: begin
					vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_q <= req_item;
		end
		if ((state_q == slri_pkg::ST_STREAM) && vld_s1 && out_ready) begin
			prev_q <= rd_data_s1;
		end
	end

	// checks
	`SLRI_ASSERT_IMPLY(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CNT_W'(slri_pkg::CAPACITY))
	`SLRI_ASSERT_IMPLY(a_wr_only_ok, clk, arst_n, mreq.wr_en,
		(state_q == slri_pkg::ST_STREAM) && (err_q == slri_pkg::ERR_NONE))
	`SLRI_ASSERT_IMPLY(a_no_rw_clash, clk, arst_n, mreq.rd_en && mreq.wr_en,
		mreq.rd_addr != mreq.wr_addr)
	`SLRI_ASSERT_NEXT(a_last_frees, clk, arst_n, load && last_res,
		state_q == slri_pkg::ST_IDLE)

endmodule

`default_nettype wire

// ----- sv/slri_store.sv -----
// Value store: one write port, one read port, registered read data.
// Depends on slri_pkg.
`default_nettype none

module slri_store (
	input  wire                            clk,
	input  slri_pkg::mem_req_t             mreq,
	output logic [slri_pkg::VAL_W-1:0]     rd_data_s1
);

	logic [slri_pkg::VAL_W-1:0] mem [slri_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[mreq.wr_addr] <= mreq.wr_data;
		end
		if (mreq.rd_en) begin
			rd_data_s1 <= mem[mreq.rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/slri_out.sv -----
// Result output register; frees the core as soon as the consumer takes a result.
// Depends on slri_pkg.
`default_nettype none

module slri_out (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  slri_pkg::res_t      load_item,
	output logic                ready,
	output logic                res_valid,
	input  wire                 res_stall,
	output slri_pkg::res_t      res_item
);

	logic           vld_q;
	slri_pkg::res_t item_q;

	assign ready     = !vld_q || !res_stall;
	assign res_valid = vld_q;
	assign res_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ready) begin
			vld_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			item_q <= load_item;
		end
	end

endmodule

`default_nettype wire
